// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design files.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== design/ppbf_pkg.sv =====
// ----------------------------------------------------------------------------
// ppbf_pkg: shared types and constants of the prime power base finder
// Field widths, sequencer states and the divider status bundle.
// ----------------------------------------------------------------------------
package ppbf_pkg;

    localparam int MODULUS_BITS_DEF = 32;
    localparam int IN_W             = 32;
    localparam int BASE_W           = 16;
    localparam int EXP_W            = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAUNCH_SEARCH,
        ST_WAIT_SEARCH,
        ST_LAUNCH_DIVOUT,
        ST_WAIT_DIVOUT,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== design/ppbf_divider.sv =====
// ----------------------------------------------------------------------------
// ppbf_divider: restoring divider, one quotient bit per cycle
// Takes a WIDTH-bit dividend and a DIV_W-bit divisor, returns both
// quotient and remainder and pulses done when the last quotient bit is in.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppbf_divider #(
    parameter int WIDTH = ppbf_pkg::MODULUS_BITS_DEF,
    parameter int DIV_W = (ppbf_pkg::MODULUS_BITS_DEF + 1) / 2 + 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [WIDTH-1:0]    dividend,
    input  logic [DIV_W-1:0]    divisor,
    output ppbf_pkg::div_stat_t stat,
    output logic [WIDTH-1:0]    quotient,
    output logic [DIV_W-1:0]    remainder
);

    localparam int CNT_W = $clog2(WIDTH);

    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;

    // The partial remainder stays below the divisor, so the trial value
    // fits in one bit more than the divisor.
    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(WIDTH - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_W])
            begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    `ASSERT_IMPL(a_rem_below_divisor, done_reg, rem_reg < dsr_reg)
    `ASSERT_NEXT(a_start_runs, start, busy_reg && !done_reg)
    `ASSERT_IMPL(a_done_not_busy, done_reg, !busy_reg)

endmodule

// ===== design/prime_power_base_finder.sv =====
// ----------------------------------------------------------------------------
// prime_power_base_finder: tests a modulus for being p^k with k of 2 or more
// Trial division over a single shared restoring divider.
// ----------------------------------------------------------------------------
// Usage: a modulus request enters on in_valid/in_ready; one result leaves on
// out_valid/out_ready with is_prime_power, base_prime and exponent. When the
// modulus is not a pure prime power the result is flag 0, base 0, exponent 1.
// The block takes one request at a time; in_ready is high only while idle.
// Each division of the shared divider is a launch, one cycle per quotient bit
// and a decision. A request takes c + k divisions, where c is the number of
// candidate divisors tried and k the multiplicity of the smallest factor.
// For a 32-bit prime near the top of the range c is about 65535, and the
// shared divider sets the run time of a request.
// After the result is computed it waits in a holding stage until the output
// register is free, so a stalled receiver holds the block in that state.
// The next request is taken once the result has moved to the output
// register. Reset returns the sequencer to idle and drops out_valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prime_power_base_finder #(
    parameter int MODULUS_BITS = ppbf_pkg::MODULUS_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ppbf_pkg::IN_W-1:0]   modulus,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        is_prime_power,
    output logic [ppbf_pkg::BASE_W-1:0] base_prime,
    output logic [ppbf_pkg::EXP_W-1:0]  exponent
);

    localparam int W     = MODULUS_BITS;
    localparam int DW    = (MODULUS_BITS + 1) / 2 + 1;
    localparam int IW    = ppbf_pkg::IN_W;
    localparam int BW    = ppbf_pkg::BASE_W;
    localparam int EW    = ppbf_pkg::EXP_W;

    ppbf_pkg::state_t state_reg, state_next;

    logic [W-1:0]  m_reg, m_next;
    logic [W-1:0]  rest_reg, rest_next;
    logic [DW-1:0] d_reg, d_next;
    logic [EW-1:0] count_reg, count_next;
    logic          flag_reg, flag_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_flag_reg, out_flag_next;
    logic [BW-1:0] out_base_reg, out_base_next;
    logic [EW-1:0] out_exp_reg, out_exp_next;

    logic                div_start;
    logic [W-1:0]        div_dividend;
    ppbf_pkg::div_stat_t div_stat;
    logic [W-1:0]        div_quo;
    logic [DW-1:0]       div_rem;

    logic [W+IW-1:0]     modulus_wide;
    logic [W-1:0]        modulus_fit;
    logic [W+DW-1:0]     d_wide;
    logic [BW+DW-1:0]    d_base_wide;
    logic                accept_in;
    logic                out_free;
    logic                d_too_big;

    // Keep only the low MODULUS_BITS bits of the request, zero-extended.
    assign modulus_wide = {{W{1'b0}}, modulus};
    assign modulus_fit  = modulus_wide[W-1:0];
    assign d_wide       = {{W{1'b0}}, d_reg};
    assign d_base_wide  = {{BW{1'b0}}, d_reg};

    assign accept_in = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    // Search ends once d exceeds m / d, that is d * d > m.
    assign d_too_big = d_wide[W-1:0] > div_quo;

    ppbf_divider #(
        .WIDTH (W),
        .DIV_W (DW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (d_reg),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ppbf_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = ppbf_pkg::ST_LAUNCH_SEARCH;
            end
            ppbf_pkg::ST_LAUNCH_SEARCH:
                state_next = ppbf_pkg::ST_WAIT_SEARCH;
            ppbf_pkg::ST_WAIT_SEARCH:
            begin
                if (div_stat.done)
                begin
                    if (d_too_big)
                        state_next = ppbf_pkg::ST_HOLD;
                    else if (div_rem != '0)
                        state_next = ppbf_pkg::ST_LAUNCH_SEARCH;
                    else
                        state_next = ppbf_pkg::ST_LAUNCH_DIVOUT;
                end
            end
            ppbf_pkg::ST_LAUNCH_DIVOUT:
                state_next = ppbf_pkg::ST_WAIT_DIVOUT;
            ppbf_pkg::ST_WAIT_DIVOUT:
            begin
                if (div_stat.done)
                begin
                    if (div_rem == '0)
                        state_next = ppbf_pkg::ST_LAUNCH_DIVOUT;
                    else
                        state_next = ppbf_pkg::ST_HOLD;
                end
            end
            ppbf_pkg::ST_HOLD:
            begin
                if (out_free)
                    state_next = ppbf_pkg::ST_IDLE;
            end
            default:
                state_next = ppbf_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb
    begin
        in_ready       = 1'b0;
        div_start      = 1'b0;
        div_dividend   = m_reg;
        m_next         = m_reg;
        rest_next      = rest_reg;
        d_next         = d_reg;
        count_next     = count_reg;
        flag_next      = flag_reg;
        out_flag_next  = out_flag_reg;
        out_base_next  = out_base_reg;
        out_exp_next   = out_exp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ppbf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    m_next     = modulus_fit;
                    d_next     = DW'(2);
                    count_next = '0;
                    flag_next  = 1'b0;
                end
            end
            ppbf_pkg::ST_LAUNCH_SEARCH:
            begin
                div_start    = 1'b1;
                div_dividend = m_reg;
            end
            ppbf_pkg::ST_WAIT_SEARCH:
            begin
                if (div_stat.done && !d_too_big)
                begin
                    if (div_rem != '0)
                        d_next = d_reg + 1'b1;
                    else
                    begin
                        // Smallest factor found; the first division counts once.
                        rest_next  = div_quo;
                        count_next = EW'(1);
                    end
                end
            end
            ppbf_pkg::ST_LAUNCH_DIVOUT:
            begin
                div_start    = 1'b1;
                div_dividend = rest_reg;
            end
            ppbf_pkg::ST_WAIT_DIVOUT:
            begin
                if (div_stat.done)
                begin
                    if (div_rem == '0)
                    begin
                        rest_next  = div_quo;
                        count_next = count_reg + 1'b1;
                    end
                    else
                        flag_next = (rest_reg == W'(1)) && (count_reg > EW'(1));
                end
            end
            ppbf_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_flag_next  = flag_reg;
                    out_base_next  = flag_reg ? d_base_wide[BW-1:0] : '0;
                    out_exp_next   = flag_reg ? count_reg : EW'(1);
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppbf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg        <= m_next;
        rest_reg     <= rest_next;
        d_reg        <= d_next;
        count_reg    <= count_next;
        flag_reg     <= flag_next;
        out_flag_reg <= out_flag_next;
        out_base_reg <= out_base_next;
        out_exp_reg  <= out_exp_next;
    end

    assign out_valid      = out_valid_reg;
    assign is_prime_power = out_flag_reg;
    assign base_prime     = out_base_reg;
    assign exponent       = out_exp_reg;

    `ASSERT_IMPL(a_start_when_free, div_start, !div_stat.busy)
    `ASSERT_NEXT(a_accept_launches, accept_in, state_reg == ppbf_pkg::ST_LAUNCH_SEARCH)
    `ASSERT_IMPL(a_power_has_exp, out_valid_reg && out_flag_reg, out_exp_reg > EW'(1))
    `ASSERT_IMPL(a_nonpower_fields, out_valid_reg && !out_flag_reg, (out_base_reg == '0) && (out_exp_reg == EW'(1)))

endmodule
